[sv/dq_pkg.sv]
// Shared constants, types and width helpers for the double-ended queue with search.
package dq_pkg;

   // Queue geometry
   localparam int CAPACITY      = 64;
   localparam int ELEMENT_WIDTH = 32;

   // Field widths at the ports
   localparam int VALUE_W = 32;
   localparam int KIND_W  = 3;
   localparam int SMALL_W = 7;
   localparam int REQ_W   = 32;
   localparam int RSP_W   = 120;

   // Counter widths that follow from the capacity
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int STEP_W = $clog2(CAPACITY);

   localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0]   FULL_CNT  = CNT_W'(CAPACITY);
   localparam logic [SMALL_W-1:0] POS_NONE  = '1;

   typedef logic [ELEMENT_WIDTH-1:0] elem_type;

   typedef enum logic [2:0] {
      KIND_PUSH_BACK  = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_FIND_FRONT = 3'd4,
      KIND_FIND_BACK  = 3'd5,
      KIND_COUNT      = 3'd6,
      KIND_CLEAR      = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_INSERT,
      CELL_LOAD
   } cell_op_type;

   // Command broadcast to every cell of the row
   typedef struct packed {
      cell_op_type      op;
      logic [CNT_W-1:0] load_idx;
      elem_type         value;
   } cell_ctrl_type;

   // Cut a port value to the element width
   function automatic elem_type fit_elem(input logic [VALUE_W-1:0] x);
      logic [ELEMENT_WIDTH+VALUE_W-1:0] w;
      w = {{ELEMENT_WIDTH{1'b0}}, x};
      return w[ELEMENT_WIDTH-1:0];
   endfunction

   // Extend or cut an element to the port value width
   function automatic logic [VALUE_W-1:0] elem_to_field(input elem_type e);
      logic [ELEMENT_WIDTH+VALUE_W-1:0] w;
      w = {{VALUE_W{1'b0}}, e};
      return w[VALUE_W-1:0];
   endfunction

   // Extend or cut a count to a seven-bit field
   function automatic logic [SMALL_W-1:0] fit7(input logic [CNT_W-1:0] x);
      logic [CNT_W+SMALL_W-1:0] w;
      w = {{SMALL_W{1'b0}}, x};
      return w[SMALL_W-1:0];
   endfunction

endpackage

[sv/dq_cell.sv]
// One storage cell of the queue row, holding the entry at its position.
module dq_cell (
   input  logic                  clock,
   input  dq_pkg::cell_ctrl_type cell_ctrl,
   input  logic                  sel,
   input  dq_pkg::elem_type      prev_value,
   input  dq_pkg::elem_type      next_value,
   output dq_pkg::elem_type      value
);

   dq_pkg::elem_type value_ff;
   dq_pkg::elem_type value_in;

   // Pick the next content: hold, take from the neighbour, or load the new item
   always_comb begin
      value_in = value_ff;
      unique case (cell_ctrl.op)
         dq_pkg::CELL_HOLD:   value_in = value_ff;
         dq_pkg::CELL_ROTATE: value_in = next_value;
         dq_pkg::CELL_INSERT: value_in = prev_value;
         dq_pkg::CELL_LOAD:   value_in = sel ? cell_ctrl.value : value_ff;
         default:             value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[sv/dq_ctrl.sv]
// Command sequencer: applies each command to the cell row, then scans it once round.
module dq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [dq_pkg::REQ_W-1:0]     req_tdata,
   input  logic [dq_pkg::KIND_W-1:0]    req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [dq_pkg::RSP_W-1:0]     rsp_tdata,
   input  dq_pkg::elem_type             head_value,
   output dq_pkg::cell_ctrl_type        cell_ctrl
);

   dq_pkg::state_type             state_ff, state_in;
   logic [dq_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [dq_pkg::CNT_W-1:0]      count_ff, count_in;
   dq_pkg::kind_type              kind_ff, kind_in;
   dq_pkg::elem_type              val_ff, val_in;
   dq_pkg::status_type            status_ff, status_in;
   dq_pkg::elem_type              popped_ff, popped_in;
   dq_pkg::elem_type              back_ff, back_in;
   logic                          found_ff, found_in;
   logic [dq_pkg::STEP_W-1:0]     first_ff, first_in;
   logic [dq_pkg::STEP_W-1:0]     last_ff, last_in;
   logic [dq_pkg::CNT_W-1:0]      matches_ff, matches_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [dq_pkg::RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   dq_pkg::kind_type              req_kind;
   dq_pkg::elem_type              req_value;
   logic [dq_pkg::CNT_W-1:0]      step_ext;
   logic                          in_range;
   logic                          hit;
   logic                          rsp_load;
   logic [dq_pkg::SMALL_W-1:0]    pos_field;
   logic [dq_pkg::SMALL_W-1:0]    match_field;
   logic [dq_pkg::VALUE_W-1:0]    front_field;
   logic [dq_pkg::VALUE_W-1:0]    back_field;

   assign req_kind  = dq_pkg::kind_type'(req_tuser);
   assign req_value = dq_pkg::fit_elem(req_tdata[dq_pkg::VALUE_W-1:0]);
   assign step_ext  = dq_pkg::CNT_W'(step_ff);
   assign in_range  = step_ext < count_ff;
   assign hit       = in_range && (head_value == val_ff);

   // Assemble the result fields from the finished scan
   always_comb begin
      pos_field = dq_pkg::POS_NONE;
      if (found_ff && kind_ff == dq_pkg::KIND_FIND_FRONT) begin
         pos_field = dq_pkg::fit7(dq_pkg::CNT_W'(first_ff));
      end else if (found_ff && kind_ff == dq_pkg::KIND_FIND_BACK) begin
         pos_field = dq_pkg::fit7(count_ff - dq_pkg::CNT_W'(1) - dq_pkg::CNT_W'(last_ff));
      end
      match_field = (kind_ff == dq_pkg::KIND_COUNT) ? dq_pkg::fit7(matches_ff) : '0;
      front_field = (count_ff != '0) ? dq_pkg::elem_to_field(head_value) : '0;
      back_field  = (count_ff != '0) ? dq_pkg::elem_to_field(back_ff) : '0;
   end

   // Next state, cell commands and scan bookkeeping
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      count_in   = count_ff;
      kind_in    = kind_ff;
      val_in     = val_ff;
      status_in  = status_ff;
      popped_in  = popped_ff;
      back_in    = back_ff;
      found_in   = found_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      matches_in = matches_ff;
      rsp_load   = 1'b0;
      cell_ctrl.op       = dq_pkg::CELL_HOLD;
      cell_ctrl.load_idx = count_ff;
      cell_ctrl.value    = req_value;

      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               // Take the item and apply its update to the row
               kind_in    = req_kind;
               val_in     = req_value;
               status_in  = dq_pkg::STATUS_OK;
               popped_in  = '0;
               step_in    = '0;
               found_in   = 1'b0;
               matches_in = '0;
               state_in   = dq_pkg::ST_SCAN;
               unique case (req_kind)
                  dq_pkg::KIND_PUSH_BACK: begin
                     if (count_ff == dq_pkg::FULL_CNT) begin
                        status_in = dq_pkg::STATUS_FULL;
                     end else begin
                        cell_ctrl.op = dq_pkg::CELL_LOAD;
                        count_in     = count_ff + dq_pkg::CNT_W'(1);
                     end
                  end
                  dq_pkg::KIND_PUSH_FRONT: begin
                     if (count_ff == dq_pkg::FULL_CNT) begin
                        status_in = dq_pkg::STATUS_FULL;
                     end else begin
                        cell_ctrl.op = dq_pkg::CELL_INSERT;
                        count_in     = count_ff + dq_pkg::CNT_W'(1);
                     end
                  end
                  dq_pkg::KIND_POP_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = dq_pkg::STATUS_EMPTY;
                     end else begin
                        popped_in    = head_value;
                        cell_ctrl.op = dq_pkg::CELL_ROTATE;
                        count_in     = count_ff - dq_pkg::CNT_W'(1);
                     end
                  end
                  dq_pkg::KIND_POP_BACK: begin
                     if (count_ff == '0) begin
                        status_in = dq_pkg::STATUS_EMPTY;
                     end else begin
                        popped_in = back_ff;
                        count_in  = count_ff - dq_pkg::CNT_W'(1);
                     end
                  end
                  dq_pkg::KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     // find and count leave the row untouched
                  end
               endcase
            end
         end
         dq_pkg::ST_SCAN: begin
            // Rotate the row once round, watching the head cell
            cell_ctrl.op = dq_pkg::CELL_ROTATE;
            if (hit) begin
               matches_in = matches_ff + dq_pkg::CNT_W'(1);
               last_in    = step_ff;
               if (!found_ff) begin
                  found_in = 1'b1;
                  first_in = step_ff;
               end
            end
            if (in_range && step_ext == count_ff - dq_pkg::CNT_W'(1)) begin
               back_in = head_value;
            end
            step_in = step_ff + dq_pkg::STEP_W'(1);
            if (step_ff == dq_pkg::LAST_STEP) begin
               state_in = dq_pkg::ST_FINISH;
            end
         end
         dq_pkg::ST_FINISH: begin
            // Hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = dq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_load ? {1'b0, status_ff, dq_pkg::fit7(count_ff), back_field,
                                 front_field, match_field, pos_field,
                                 dq_pkg::elem_to_field(popped_ff)}
                              : rsp_data_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan registers
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      kind_ff     <= kind_in;
      val_ff      <= val_in;
      status_ff   <= status_in;
      popped_ff   <= popped_in;
      back_ff     <= back_in;
      found_ff    <= found_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      matches_ff  <= matches_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == dq_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Occupancy never passes the capacity
   assert property (@(posedge clock) disable iff (reset) count_ff <= dq_pkg::FULL_CNT)
      else $error("occupancy above capacity");

   // An accepted item always starts a scan
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == dq_pkg::ST_SCAN))
      else $error("accepted item did not start a scan");

   // The scan ends after the last cell position
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == dq_pkg::ST_SCAN && step_ff == dq_pkg::LAST_STEP)
         |=> (state_ff == dq_pkg::ST_FINISH))
      else $error("scan did not finish after a full turn");

   // A first match is recorded exactly when matches were counted
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != dq_pkg::ST_IDLE) |-> (found_ff == (matches_ff != '0)))
      else $error("match flag and match count disagree");

   // Occupancy holds steady through a scan
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == dq_pkg::ST_SCAN && step_ff != '0) |-> $stable(count_ff))
      else $error("occupancy changed during a scan");

endmodule

[sv/double_ended_queue_with_search.sv]
// Top level of the double-ended queue with search: a row of storage cells and its sequencer.
//
// Usage:
//   The req channel carries one command per item: req_tuser holds the command kind
//   (push back, push front, pop front, pop back, find from front, find from back,
//   count, clear) and req_tdata the value to push, find or count. The rsp channel
//   returns exactly one item per command with the popped value, the find position
//   (all ones when nothing matches), the match count, front and back values,
//   occupancy and a status (ok, pop from empty, push into full dropped).
//   Entries sit in a row of CAPACITY cells, the front always in the first cell.
//   After its update every command turns the whole row once round, one cell
//   position per cycle, so the sequencer sees each entry at the head cell to find
//   matches and the new back value.
//   The update lands when the item is accepted; the scan then steps through every
//   cell position in ST_SCAN, and ST_FINISH hands the result to the output register.
//   The next item is accepted only once the sequencer is back in idle, so an item
//   is not taken while an earlier one is still being updated, scanned or handed over.
//   Reset empties the queue; stored entries are left as they are but never read.
//   When the receiver stalls, the finished result waits in the output register
//   and a new item is still taken; its result waits until that register is free.
module double_ended_queue_with_search (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [dq_pkg::REQ_W-1:0]  req_tdata,   // value_in
   input  logic [dq_pkg::KIND_W-1:0] req_tuser,   // kind
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [dq_pkg::RSP_W-1:0]  rsp_tdata    // popped_value, position, match_count,
                                                  // front_value, back_value, occupancy,
                                                  // status, zero pad
);

   dq_pkg::cell_ctrl_type cell_ctrl;
   dq_pkg::elem_type      cell_value [dq_pkg::CAPACITY];

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .head_value (cell_value[0]),
      .cell_ctrl  (cell_ctrl)
   );

   // Build the row; the last cell takes from the first when the row turns
   for (genvar i = 0; i < dq_pkg::CAPACITY; i++) begin : g_cell
      dq_pkg::elem_type prev_value;
      dq_pkg::elem_type next_value;
      logic             sel;

      if (i == 0) begin : g_first
         assign prev_value = cell_ctrl.value;
      end else begin : g_mid
         assign prev_value = cell_value[i-1];
      end

      if (i == dq_pkg::CAPACITY - 1) begin : g_last
         assign next_value = cell_value[0];
      end else begin : g_inner
         assign next_value = cell_value[i+1];
      end

      assign sel = (cell_ctrl.load_idx == dq_pkg::CNT_W'(i));

      dq_cell u_cell (
         .clock      (clock),
         .cell_ctrl  (cell_ctrl),
         .sel        (sel),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[i])
      );
   end

endmodule
